// File: src/olrc_pkg.sv
// ----------------------------------------------------------------------------
// olrc_pkg
// Shared types and fixed widths for the overwriting log ring with cursors.
// ----------------------------------------------------------------------------
package olrc_pkg;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAXB_W = 7;

  typedef enum logic [1:0] {
    OP_WRITE       = 2'd0,
    OP_READ_CURSOR = 2'd1,
    OP_READ_OWN    = 2'd2,
    OP_CLEAR       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_LIMIT,
    ST_COMMIT,
    ST_EMPTY,
    ST_STREAM
  } state_e;

endpackage

// File: src/overwriting_log_ring_with_cursors.sv
// ----------------------------------------------------------------------------
// overwriting_log_ring_with_cursors
// Byte log ring with free-running write, read and drop counters.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_* channel (valid/ready) and results leave on
// the out_* channel (valid/ready) from an output register, so a new item may
// be taken in the cycle the previous result transfer completes.
// A write or a clear gives its result in the next cycle; back-to-back
// writes run at one byte per cycle while the receiver takes each result.
// A read first passes the clamp, limit and commit states, which clamp the
// start position, size the burst (one wide subtract and compare in each of
// the first two) and set up the stream; it then streams its n bytes out of
// the ring memory through its read register at one byte per cycle while the
// receiver keeps up, and the next item is taken once the last byte has left.
// When the receiver stalls, the output register holds its result and one
// further byte waits in the memory read register; no more reads are issued
// until the receiver takes data again.
// Reset clears all counters and the control logic; the ring contents are
// undefined until written and need no clearing pass. RING_BYTES must be a
// power of two.
// ----------------------------------------------------------------------------
module overwriting_log_ring_with_cursors
  import olrc_pkg::*;
#(
  parameter int unsigned RING_BYTES = 4096,
  parameter int unsigned MAX_BURST  = 64,
  localparam int unsigned PW = $clog2(RING_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_write_i,
  input  logic [CNT_W-1:0]  cursor_i,
  input  logic [MAXB_W-1:0] max_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              byte_valid_o,
  output logic              last_o,
  output logic [CNT_W-1:0]  next_cursor_o,
  output logic [CNT_W-1:0]  skipped_bytes_o,
  output logic [PW-1:0]     pending_bytes_o,
  output logic [CNT_W-1:0]  dropped_count_o
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned CW = $clog2(MAX_BURST + 1);

  function automatic logic [PW-1:0] sat_pending(input logic [CNT_W-1:0] span);
    if (span > CNT_W'(RING_BYTES)) begin
      return PW'(RING_BYTES);
    end
    return span[PW-1:0];
  endfunction

  // Ring memory and its registered read data.
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  logic [BYTE_W-1:0] mem_q;
  logic              mem_we;
  logic              mem_re;

  state_e            state_q, state_d;
  op_e               op_q, op_d, op_in;
  logic [CNT_W-1:0]  wc_q, wc_d;
  logic [CNT_W-1:0]  rc_q, rc_d;
  logic [CNT_W-1:0]  drop_q, drop_d;
  logic [CNT_W-1:0]  diff_q, diff_d;
  logic [CNT_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0]  start_q, start_d;
  logic [CNT_W-1:0]  lost_q, lost_d;
  logic [CNT_W-1:0]  d2_q, d2_d;
  logic [CNT_W-1:0]  next_q, next_d;
  logic [CW-1:0]     maxb_q, maxb_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     remain_q, remain_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              last_q, last_d;
  logic [CNT_W-1:0]  out_next_q, out_next_d;
  logic [CNT_W-1:0]  out_lost_q, out_lost_d;
  logic [PW-1:0]     out_pend_q, out_pend_d;
  logic [CNT_W-1:0]  out_drop_q, out_drop_d;
  logic              out_load;

  logic              in_acc;
  logic              out_free;
  logic              is_read;
  logic [CNT_W-1:0]  start_in;
  logic [CNT_W-1:0]  d1;
  logic [CNT_W-1:0]  d2;
  logic [CNT_W-1:0]  sum;
  logic              mem_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign op_in      = op_e'(operation_i);
  assign is_read    = (op_in == OP_READ_CURSOR) || (op_in == OP_READ_OWN);
  assign start_in   = (op_in == OP_READ_OWN) ? rc_q : cursor_i;
  assign d1         = start_q - oldest_q;
  assign d2         = wc_q - start_q;
  assign sum        = start_q + CNT_W'(count_q);

  // A byte in the read register moves to the output register when it frees;
  // a new read is issued only when the read register will be empty.
  assign mem_load = (state_q == ST_STREAM) && pend_q && out_free;
  assign mem_re   = (state_q == ST_STREAM) && (remain_q != '0) && (!pend_q || mem_load);
  assign mem_we   = in_acc && (op_in == OP_WRITE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_read && (max_bytes_i != '0)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP:  state_d = ST_LIMIT;
      ST_LIMIT:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = (count_q == '0) ? ST_EMPTY : ST_STREAM;
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (mem_load && pend_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters and read set-up.
  always_comb begin
    op_d        = op_q;
    wc_d        = wc_q;
    rc_d        = rc_q;
    drop_d      = drop_q;
    diff_d      = diff_q;
    oldest_d    = oldest_q;
    start_d     = start_q;
    lost_d      = lost_q;
    d2_d        = d2_q;
    next_d      = next_q;
    maxb_d      = maxb_q;
    count_d     = count_q;
    remain_d    = remain_q;
    rd_addr_d   = rd_addr_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_in)
            OP_WRITE: begin
              wc_d   = wc_q + 1'b1;
              diff_d = diff_q + 1'b1;
              if (diff_q >= CNT_W'(RING_BYTES)) begin
                drop_d = drop_q + 1'b1;
              end
              // The oldest held byte moves only while the advanced write
              // counter lies above the ring size, so not when it wraps to 0.
              oldest_d = ((wc_q >= CNT_W'(RING_BYTES)) && (wc_q != '1)) ?
                         wc_q - CNT_W'(RING_BYTES - 1) : '0;
            end
            OP_CLEAR: begin
              wc_d     = '0;
              rc_d     = '0;
              drop_d   = '0;
              diff_d   = '0;
              oldest_d = '0;
            end
            default: begin
              op_d    = op_in;
              start_d = start_in;
              maxb_d  = (max_bytes_i > MAXB_W'(MAX_BURST)) ?
                        CW'(MAX_BURST) : max_bytes_i[CW-1:0];
            end
          endcase
        end
      end
      ST_CLAMP: begin
        // A start older than the oldest held byte moves up to it.
        if (d1[CNT_W-1]) begin
          start_d = oldest_q;
          lost_d  = oldest_q - start_q;
        end else begin
          lost_d  = '0;
        end
      end
      ST_LIMIT: begin
        // A start ahead of the writer moves back to it and returns nothing.
        if (d2[CNT_W-1]) begin
          start_d = wc_q;
          d2_d    = '0;
          count_d = '0;
        end else begin
          d2_d    = d2;
          count_d = (d2 > CNT_W'(maxb_q)) ? maxb_q : d2[CW-1:0];
        end
      end
      ST_COMMIT: begin
        next_d    = sum;
        rd_addr_d = start_q[AW-1:0];
        remain_d  = count_q;
        if (op_q == OP_READ_OWN) begin
          rc_d   = sum;
          diff_d = d2_q - CNT_W'(count_q);
          lost_d = '0;
        end
      end
      ST_STREAM: begin
        if (mem_re) begin
          rd_addr_d   = rd_addr_q + 1'b1;
          remain_d    = remain_q - 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (remain_q == CW'(1));
        end else if (mem_load) begin
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result register loading.
  always_comb begin
    out_load     = 1'b0;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    out_next_d   = out_next_q;
    out_lost_d   = out_lost_q;
    out_pend_d   = out_pend_q;
    out_drop_d   = out_drop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_byte_d   = '0;
          byte_valid_d = 1'b0;
          last_d       = 1'b1;
          out_next_d   = '0;
          out_lost_d   = '0;
          case (op_in)
            OP_WRITE: begin
              out_load   = 1'b1;
              out_pend_d = sat_pending(diff_q + 1'b1);
              out_drop_d = drop_d;
            end
            OP_CLEAR: begin
              out_load   = 1'b1;
              out_pend_d = '0;
              out_drop_d = '0;
            end
            default: begin
              out_load   = (max_bytes_i == '0);
              out_next_d = start_in;
              out_pend_d = sat_pending(diff_q);
              out_drop_d = drop_q;
            end
          endcase
        end
      end
      ST_EMPTY: begin
        out_load     = out_free;
        out_byte_d   = '0;
        byte_valid_d = 1'b0;
        last_d       = 1'b1;
        out_next_d   = start_q;
        out_lost_d   = lost_q;
        out_pend_d   = sat_pending(diff_q);
        out_drop_d   = drop_q;
      end
      ST_STREAM: begin
        out_load     = mem_load;
        out_byte_d   = mem_q;
        byte_valid_d = 1'b1;
        last_d       = pend_last_q;
        out_next_d   = next_q;
        out_lost_d   = lost_q;
        out_pend_d   = sat_pending(diff_q);
        out_drop_d   = drop_q;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_WRITE;
      wc_q        <= '0;
      rc_q        <= '0;
      drop_q      <= '0;
      diff_q      <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      remain_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      wc_q        <= wc_d;
      rc_q        <= rc_d;
      drop_q      <= drop_d;
      diff_q      <= diff_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    lost_q       <= lost_d;
    d2_q         <= d2_d;
    next_q       <= next_d;
    maxb_q       <= maxb_d;
    rd_addr_q    <= rd_addr_d;
    // The result payload changes only when a new result is loaded, so it
    // stays put while the receiver stalls.
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      out_next_q   <= out_next_d;
      out_lost_q   <= out_lost_d;
      out_pend_q   <= out_pend_d;
      out_drop_q   <= out_drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wc_q[AW-1:0]] <= data_byte_i;
    end
    if (mem_re) begin
      mem_q <= ring_mem[rd_addr_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign last_o          = last_q;
  assign next_cursor_o   = out_next_q;
  assign skipped_bytes_o = out_lost_q;
  assign pending_bytes_o = out_pend_q;
  assign dropped_count_o = out_drop_q;

  // The unread span is kept alongside the counters and must match them.
  a_diff_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    diff_q == wc_q - rc_q)
    else $error("unread span register out of step with the counters");

  a_oldest_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q == ((wc_q > CNT_W'(RING_BYTES)) ? wc_q - CNT_W'(RING_BYTES) : '0))
    else $error("oldest held position out of step with the write counter");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !mem_load |-> !mem_re)
    else $error("memory read issued over a byte not yet taken");

  a_burst_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |-> count_q <= maxb_q)
    else $error("burst longer than the requested byte count");

  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q && (remain_q == '0))
    else $error("new item taken while a read burst is still open");

endmodule
